// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ETFDM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ETFDM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/etfdm_pkg.sv =====
package etfdm_pkg;

   // Field widths.
   localparam int TS_W     = 64;
   localparam int WORD_W   = 32;
   localparam int DUTY_W   = 10;

   // Packed widths of the stream payloads, rounded up to whole bytes.
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 144;

   // Bit positions of the result fields inside rsp_tdata.
   localparam int RSP_VALID_LSB = 0;
   localparam int RSP_OK_LSB    = 1;
   localparam int RSP_EDGES_LSB = 2;
   localparam int RSP_FREQ_LSB  = 34;
   localparam int RSP_PER_LSB   = 66;
   localparam int RSP_DUTY_LSB  = 98;
   localparam int RSP_AGE_LSB   = 108;

   // Request kinds carried on req_tuser.
   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Reset value of the tick rate register.
   localparam logic [WORD_W-1:0] TPS_RESET = 32'd1032258;

   // Largest duty value a read can report.
   localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1000;

   // Division passes run by the shared unit during a read.
   typedef enum logic [1:0] {
      JOB_AGE,
      JOB_FREQ,
      JOB_PER,
      JOB_DUTY
   } job_type;

   // Iteration counts of each division, sized to the numerator width.
   localparam logic [6:0] STEPS_AGE  = 7'd64;
   localparam logic [6:0] STEPS_FREQ = 7'd32;
   localparam logic [6:0] STEPS_PER  = 7'd52;
   localparam logic [6:0] STEPS_DUTY = 7'd42;

endpackage

// ===== src/edge_timestamp_frequency_duty_meter_unit.sv =====
// Edge event: the block is ready again in the next cycle, no result.
// Read request: age is always computed; frequency, period and duty only when a
// valid period is held. The work is done by one shared 64-bit subtractor doing
// restoring division a bit per cycle.
// Synchronous active-high reset clears all measurement state, drops rsp_tvalid
// and loads the tick rate register with 1032258.
module edge_timestamp_frequency_duty_meter_unit
   import etfdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: pin_flagged[0], level_high[1], timestamp[65:2], zero pad[71:66].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: func (0 = edge event, 1 = read request).
   input  logic                  req_tuser,
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: valid_res[0], measure_ok[1], edge_count[33:2], frequency_hz[65:34],
   // period_us[97:66], duty_permille[107:98], age_ms[139:108], zero pad[143:140].
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Tick rate register write channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WORD_W-1:0]     csr_data
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_NEXT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]            state_ff, state_in;
   job_type               job_ff, job_in;
   logic                  pass_ff, pass_in;
   logic [6:0]            cnt_ff, cnt_in;

   // Measurement state.
   logic [WORD_W-1:0]     tps_ff, tps_in;
   logic [TS_W-1:0]       last_rise_ff, last_rise_in;
   logic [WORD_W-1:0]     period_ff, period_in;
   logic [WORD_W-1:0]     high_ff, high_in;
   logic [WORD_W-1:0]     edges_ff, edges_in;
   logic                  seen_rise_ff, seen_rise_in;
   logic                  seen_period_ff, seen_period_in;
   logic                  seen_high_ff, seen_high_in;

   // Datapath of the shared unit.
   logic [TS_W-1:0]       num_ff, num_in;
   logic [TS_W-1:0]       tmp_ff, tmp_in;
   logic [WORD_W-1:0]     rem_ff, rem_in;
   logic [WORD_W-1:0]     den_ff, den_in;
   logic [WORD_W-1:0]     age_ff, age_in;
   logic [WORD_W-1:0]     freq_ff, freq_in;
   logic [WORD_W-1:0]     per_ff, per_in;
   logic [DUTY_W-1:0]     duty_ff, duty_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  in_flagged;
   logic                  in_level;
   logic [TS_W-1:0]       in_ts;
   logic [TS_W-1:0]       sub_a;
   logic [TS_W-1:0]       sub_b;
   logic [TS_W:0]         sub_res;
   logic                  sub_borrow;
   logic                  ts_later;
   logic                  meas_ok;
   logic                  duty_go;
   logic [WORD_W-1:0]     quot;
   logic                  rsp_free;

   assign in_flagged = req_tdata[0];
   assign in_level   = req_tdata[1];
   assign in_ts      = req_tdata[TS_W+1:2];

   // Neither channel takes a transfer while reset is held.
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Operand selection for the one shared subtractor.
   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin
            sub_a = tmp_ff << 10;
            sub_b = tmp_ff << 4;
         end
         ST_MUL2: begin
            sub_a = num_ff;
            sub_b = tmp_ff << 3;
         end
         ST_DIV: begin
            sub_a = {31'd0, rem_ff, num_ff[TS_W-1]};
            sub_b = {32'd0, den_ff};
         end
         default: begin
            sub_a = in_ts;
            sub_b = last_rise_ff;
         end
      endcase
   end

   assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_res[TS_W];
   assign ts_later   = !sub_borrow && (sub_res[TS_W-1:0] != '0);

   // A division by a zero tick rate reports zero.
   assign quot     = (den_ff == '0) ? '0 : num_ff[WORD_W-1:0];
   assign meas_ok  = seen_period_ff && (period_ff != '0);
   assign duty_go  = seen_high_ff && (high_ff <= period_ff);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Sequencer and next-state logic.
   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      pass_in        = pass_ff;
      cnt_in         = cnt_ff;
      tps_in         = tps_ff;
      last_rise_in   = last_rise_ff;
      period_in      = period_ff;
      high_in        = high_ff;
      edges_in       = edges_ff;
      seen_rise_in   = seen_rise_ff;
      seen_period_in = seen_period_ff;
      seen_high_in   = seen_high_ff;
      num_in         = num_ff;
      tmp_in         = tmp_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      age_in         = age_ff;
      freq_in        = freq_ff;
      per_in         = per_ff;
      duty_in        = duty_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (csr_valid && csr_ready) begin
         tps_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == FUNC_EDGE)) begin
               // Edge event: the subtractor holds timestamp minus last rise.
               if (in_flagged) begin
                  edges_in = edges_ff + 32'd1;
                  if (in_level) begin
                     last_rise_in = in_ts;
                     seen_rise_in = 1'b1;
                     if (seen_rise_ff && ts_later) begin
                        period_in      = sub_res[WORD_W-1:0];
                        seen_period_in = 1'b1;
                     end
                  end else if (seen_rise_ff && ts_later) begin
                     high_in      = sub_res[WORD_W-1:0];
                     seen_high_in = 1'b1;
                  end
               end
            end else if (req_fire) begin
               // Read request: start with the time since the last rise.
               tmp_in   = sub_res[TS_W-1:0];
               job_in   = JOB_AGE;
               pass_in  = 1'b0;
               freq_in  = '0;
               per_in   = '0;
               duty_in  = '0;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            // First half of a multiply by 1000: x*1024 - x*16.
            num_in   = sub_res[TS_W-1:0];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // Second half: subtract x*8.
            if (pass_ff) begin
               tmp_in   = sub_res[TS_W-1:0];
               pass_in  = 1'b0;
               state_in = ST_MUL1;
            end else begin
               rem_in   = '0;
               state_in = ST_DIV;
               case (job_ff)
                  JOB_PER: begin
                     num_in = sub_res[TS_W-1:0] << 12;
                     den_in = tps_ff;
                     cnt_in = STEPS_PER;
                  end
                  JOB_DUTY: begin
                     num_in = sub_res[TS_W-1:0] << 22;
                     den_in = period_ff;
                     cnt_in = STEPS_DUTY;
                  end
                  default: begin
                     num_in = sub_res[TS_W-1:0];
                     den_in = tps_ff;
                     cnt_in = STEPS_AGE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            // One restoring division step; quotient bits shift into num.
            if (sub_borrow) begin
               rem_in = sub_a[WORD_W-1:0];
            end else begin
               rem_in = sub_res[WORD_W-1:0];
            end
            num_in = {num_ff[TS_W-2:0], !sub_borrow};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            // Store the quotient and set up the next pass, or finish.
            case (job_ff)
               JOB_AGE: begin
                  age_in = quot;
                  if (meas_ok) begin
                     job_in   = JOB_FREQ;
                     num_in   = {tps_ff, 32'd0};
                     den_in   = period_ff;
                     rem_in   = '0;
                     cnt_in   = STEPS_FREQ;
                     state_in = ST_DIV;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               JOB_FREQ: begin
                  freq_in  = quot;
                  job_in   = JOB_PER;
                  tmp_in   = {32'd0, period_ff};
                  pass_in  = 1'b1;
                  state_in = ST_MUL1;
               end
               JOB_PER: begin
                  per_in = quot;
                  if (duty_go) begin
                     job_in   = JOB_DUTY;
                     tmp_in   = {32'd0, high_ff};
                     pass_in  = 1'b0;
                     state_in = ST_MUL1;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  duty_in  = quot[DUTY_W-1:0];
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, age_ff, duty_ff, per_ff, freq_ff, edges_ff,
                               meas_ok, seen_period_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and measurement state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         job_ff         <= JOB_AGE;
         pass_ff        <= 1'b0;
         cnt_ff         <= '0;
         tps_ff         <= TPS_RESET;
         last_rise_ff   <= '0;
         period_ff      <= '0;
         high_ff        <= '0;
         edges_ff       <= '0;
         seen_rise_ff   <= 1'b0;
         seen_period_ff <= 1'b0;
         seen_high_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         job_ff         <= job_in;
         pass_ff        <= pass_in;
         cnt_ff         <= cnt_in;
         tps_ff         <= tps_in;
         last_rise_ff   <= last_rise_in;
         period_ff      <= period_in;
         high_ff        <= high_in;
         edges_ff       <= edges_in;
         seen_rise_ff   <= seen_rise_in;
         seen_period_ff <= seen_period_in;
         seen_high_ff   <= seen_high_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      tmp_ff      <= tmp_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      age_ff      <= age_in;
      freq_ff     <= freq_in;
      per_ff      <= per_in;
      duty_ff     <= duty_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== src/etfdm_checker.sv =====
`include "assert_macros.svh"

module etfdm_checker
   import etfdm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [WORD_W-1:0]     csr_data
);

   logic              rsp_ok;
   logic              rsp_vres;
   logic [DUTY_W-1:0] rsp_duty;
   logic [63:0]       rsp_freq_per;

   assign rsp_ok       = rsp_tdata[RSP_OK_LSB];
   assign rsp_vres     = rsp_tdata[RSP_VALID_LSB];
   assign rsp_duty     = rsp_tdata[RSP_DUTY_LSB +: DUTY_W];
   assign rsp_freq_per = rsp_tdata[RSP_FREQ_LSB +: 64];

   // A stalled result stays on the bus unchanged.
   `ETFDM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // A read keeps the block busy in the next cycle.
   `ETFDM_ASSERT_NEXT(a_read_busy, req_tvalid && req_tready && (req_tuser == FUNC_READ),
      !req_tready, "block took an item right after a read")

   // A computed measurement needs a measured period.
   `ETFDM_ASSERT_NOW(a_ok_valid, rsp_tvalid && rsp_ok, rsp_vres,
      "measure_ok without valid_res")

   // Without a usable period the derived values are zero.
   `ETFDM_ASSERT_NOW(a_zero_fields, rsp_tvalid && !rsp_ok,
      (rsp_freq_per == '0) && (rsp_duty == '0), "derived fields not zero")

   // Duty never exceeds full scale.
   `ETFDM_ASSERT_NOW(a_duty_range, rsp_tvalid, rsp_duty <= DUTY_MAX,
      "duty above 1000 permille")

   // Inputs that the checks above do not look at.
   logic unused_in;
   assign unused_in = ^{req_tdata, csr_valid, csr_ready, csr_data};

endmodule

bind edge_timestamp_frequency_duty_meter_unit etfdm_checker u_etfdm_checker (.*);

// ===== tb/tb_edge_timestamp_frequency_duty_meter_unit.sv =====
module tb_edge_timestamp_frequency_duty_meter_unit;
   import etfdm_pkg::*;

   // Pin level after an edge.
   localparam logic LEVEL_RISE = 1'b1;
   localparam logic LEVEL_FALL = 1'b0;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int READ_LATENCY = 250;

   typedef struct {
      logic        func;
      logic        flagged;
      logic        level;
      logic [63:0] ts;
   } pin_event_type;

   typedef struct {
      logic               valid_res;
      logic               measure_ok;
      logic [WORD_W-1:0]  edge_count;
      logic [WORD_W-1:0]  frequency_hz;
      logic [WORD_W-1:0]  period_us;
      logic [DUTY_W-1:0]  duty_permille;
      logic [WORD_W-1:0]  age_ms;
   } meter_reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [WORD_W-1:0]     csr_data = '0;

   edge_timestamp_frequency_duty_meter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Our own copy of the meter state and tick rate.
   logic [WORD_W-1:0] rate_copy = TPS_RESET;
   logic [63:0]       last_rise_copy = '0;
   logic [63:0]       prev_rise_copy = '0;
   logic [63:0]       last_fall_copy = '0;
   logic [WORD_W-1:0] period_copy = '0;
   logic [WORD_W-1:0] high_copy = '0;
   logic [WORD_W-1:0] edges_copy = '0;
   logic              rise_seen_copy = 1'b0;
   logic              period_seen_copy = 1'b0;
   logic              high_seen_copy = 1'b0;

   pin_event_type     pending_events[$];
   meter_reading_type expected_readings[$];

   pin_event_type cur_event;
   logic        event_in_flight = 1'b0;
   int          send_gap = 0;
   int          send_calm = 0;
   int          sink_stall = 0;
   int          sink_calm = 0;
   bit          failed = 1'b0;
   int          cycle_count = 0;
   logic [63:0] pulse_time;

   // Apply one accepted event to the meter copy; a read yields an expected reading.
   task automatic apply_pin_event(input pin_event_type ev);
      meter_reading_type rd;
      logic [63:0]    scaled;
      logic [63:0]    quotient;
      if (ev.func == FUNC_EDGE) begin
         if (ev.flagged) begin
            edges_copy = edges_copy + 1'b1;
            if (ev.level == LEVEL_RISE) begin
               prev_rise_copy = last_rise_copy;
               last_rise_copy = ev.ts;
               if (rise_seen_copy && last_rise_copy > prev_rise_copy) begin
                  scaled = last_rise_copy - prev_rise_copy;
                  period_copy = scaled[31:0];
                  period_seen_copy = 1'b1;
               end
               rise_seen_copy = 1'b1;
            end else begin
               last_fall_copy = ev.ts;
               if (rise_seen_copy && last_fall_copy > last_rise_copy) begin
                  scaled = last_fall_copy - last_rise_copy;
                  high_copy = scaled[31:0];
                  high_seen_copy = 1'b1;
               end
            end
         end
      end else begin
         rd.valid_res = period_seen_copy;
         rd.measure_ok = period_seen_copy && period_copy != 0;
         rd.edge_count = edges_copy;
         rd.frequency_hz = '0;
         rd.period_us = '0;
         rd.duty_permille = '0;
         // Age wraps modulo 2^64 before the division.
         scaled = (ev.ts - last_rise_copy) * 64'd1000;
         quotient = (rate_copy == 0) ? 64'd0 : scaled / {32'd0, rate_copy};
         rd.age_ms = quotient[31:0];
         if (rd.measure_ok) begin
            rd.frequency_hz = (rate_copy == 0) ? '0 : rate_copy / period_copy;
            scaled = {32'd0, period_copy} * 64'd1000000;
            quotient = (rate_copy == 0) ? 64'd0 : scaled / {32'd0, rate_copy};
            rd.period_us = quotient[31:0];
            if (high_seen_copy && high_copy <= period_copy) begin
               quotient = ({32'd0, high_copy} * 64'd1000) / {32'd0, period_copy};
               rd.duty_permille = quotient[DUTY_W-1:0];
            end
         end
         expected_readings.push_back(rd);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   task automatic check_reading(input logic [RSP_DATA_W-1:0] d);
      meter_reading_type want;
      if (expected_readings.size() == 0) begin
         $display("%0t: unexpected result transfer 0x%0h", $time, d);
         failed = 1'b1;
      end else begin
         want = expected_readings.pop_front();
         check_field("valid_res", want.valid_res, d[RSP_VALID_LSB]);
         check_field("measure_ok", want.measure_ok, d[RSP_OK_LSB]);
         check_field("edge_count", want.edge_count, d[RSP_EDGES_LSB +: WORD_W]);
         check_field("frequency_hz", want.frequency_hz, d[RSP_FREQ_LSB +: WORD_W]);
         check_field("period_us", want.period_us, d[RSP_PER_LSB +: WORD_W]);
         check_field("duty_permille", want.duty_permille, d[RSP_DUTY_LSB +: DUTY_W]);
         check_field("age_ms", want.age_ms, d[RSP_AGE_LSB +: WORD_W]);
      end
   endtask

   // Idle length: mostly none or short, a few long, with calm stretches of no idling.
   function automatic int pick_gap(ref int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm_left = $urandom_range(20, 120);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Request driver: presents queued events and predicts each accepted transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_pin_event(cur_event);
            event_in_flight = 1'b0;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               cur_event = pending_events.pop_front();
               event_in_flight = 1'b1;
               req_tvalid <= 1'b1;
               req_tuser <= cur_event.func;
               req_tdata <= {{(REQ_DATA_W-TS_W-2){1'b0}}, cur_event.ts,
                             cur_event.level, cur_event.flagged};
               send_gap = pick_gap(send_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each result transfer and stalls the stream at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_reading(rsp_tdata);
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_tready <= 1'b0;
         end else begin
            sink_stall = ($urandom_range(0, 3) == 0) ? pick_gap(sink_calm) : 0;
            rsp_tready <= (sink_stall == 0);
         end
      end
   end

   // Cycle limit in case the block hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_edge_timestamp_frequency_duty_meter_unit NOT OK");
      $finish;
   end

   task automatic push_event(input logic func, input logic flagged, input logic level,
                             input logic [63:0] ts);
      pin_event_type ev;
      ev.func = func;
      ev.flagged = flagged;
      ev.level = level;
      ev.ts = ts;
      pending_events.push_back(ev);
   endtask

   function automatic logic [63:0] random_ts();
      return {$urandom, $urandom};
   endfunction

   // Wait until every queued event is accepted and every reading has come back.
   task automatic wait_until_idle();
      while (pending_events.size() != 0 || event_in_flight || expected_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tick_rate(input logic [WORD_W-1:0] rate);
      csr_valid <= 1'b1;
      csr_data <= rate;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rate_copy = rate;
   endtask

   // Time between rises: mostly short, some long, a few beyond 32 bits.
   function automatic logic [63:0] pick_period();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return 64'd0;
      if (roll < 60) return 64'($urandom_range(1, 3000));
      if (roll < 85) return 64'($urandom_range(3001, 2000000));
      if (roll < 95) return {32'd0, $urandom};
      if (roll < 97) return 64'h1_0000_0000;
      return {30'd0, 2'($urandom_range(1, 3)), $urandom};
   endfunction

   function automatic logic [63:0] pick_high(input logic [63:0] period);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return 64'd0;
      if (roll < 14) return period;
      if (roll < 22) return period + 64'($urandom_range(1, 100));
      if (period[63:32] != 0) return {32'd0, $urandom};
      return 64'($urandom_range(0, period[31:0]));
   endfunction

   task automatic push_read_near(input logic [63:0] base);
      if ($urandom_range(0, 9) == 0) begin
         push_event(FUNC_READ, 1'($urandom), 1'($urandom), random_ts());
      end else begin
         push_event(FUNC_READ, 1'($urandom), 1'($urandom),
                    base + 64'($urandom_range(0, 5000000)));
      end
   endtask

   // Mostly well-formed pulse trains with random timing, plus noise and broken edges.
   task automatic add_random_events(input int count);
      int          added;
      int          roll;
      logic [63:0] period;
      logic [63:0] high_len;
      added = 0;
      while (added < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            period = pick_period();
            high_len = pick_high(period);
            push_event(FUNC_EDGE, 1'b1, LEVEL_RISE, pulse_time);
            added++;
            if ($urandom_range(0, 4) == 0) begin
               push_read_near(pulse_time);
               added++;
            end
            push_event(FUNC_EDGE, 1'b1, LEVEL_FALL, pulse_time + high_len);
            added++;
            if ($urandom_range(0, 1) == 0) begin
               push_read_near(pulse_time + high_len);
               added++;
            end
            pulse_time = pulse_time + period;
         end else if (roll < 78) begin
            // Ignored edge; not counted.
            push_event(FUNC_EDGE, 1'b0, 1'($urandom), random_ts());
         end else if (roll < 86) begin
            case ($urandom_range(0, 2))
               0: push_event(FUNC_EDGE, 1'b1, 1'($urandom), random_ts());
               1: push_event(FUNC_EDGE, 1'b1, 1'($urandom),
                             pulse_time - 64'($urandom_range(0, 5000)));
               default: push_event(FUNC_EDGE, 1'b1, 1'($urandom), pulse_time);
            endcase
            added++;
         end else if (roll < 96) begin
            push_read_near(pulse_time);
            added++;
         end else begin
            pulse_time = random_ts();
         end
      end
   endtask

   initial begin
      pulse_time = random_ts();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset tick rate.
      push_event(FUNC_READ, 1'b0, 1'b0, 64'd5000000);              // no rise yet
      push_event(FUNC_EDGE, 1'b0, LEVEL_RISE, 64'd100);            // unflagged edge
      push_event(FUNC_EDGE, 1'b1, LEVEL_FALL, 64'd50);             // fall before any rise
      push_event(FUNC_EDGE, 1'b1, LEVEL_RISE, 64'd1000);
      push_event(FUNC_READ, 1'b1, 1'b1, 64'd2000);                 // rise but no period
      push_event(FUNC_EDGE, 1'b1, LEVEL_FALL, 64'd1000);           // fall at the rise time
      push_event(FUNC_EDGE, 1'b1, LEVEL_RISE, 64'd1000);           // rise at the same time
      push_event(FUNC_EDGE, 1'b1, LEVEL_RISE, 64'd11000);
      push_event(FUNC_READ, 1'b0, 1'b1, 64'd12000);                // period, no high time
      push_event(FUNC_EDGE, 1'b1, LEVEL_FALL, 64'd14000);
      push_event(FUNC_READ, 1'b1, 1'b0, 64'd15000);
      push_event(FUNC_EDGE, 1'b1, LEVEL_FALL, 64'd30000);          // high time above period
      push_event(FUNC_READ, 1'b0, 1'b0, 64'd31000);
      push_event(FUNC_EDGE, 1'b1, LEVEL_RISE, 64'h1_0000_2AF8);    // period truncates to zero
      push_event(FUNC_READ, 1'b1, 1'b1, 64'h1_0000_3000);
      push_event(FUNC_EDGE, 1'b1, LEVEL_RISE, 64'h1_0000_2AFA);    // period of two ticks
      push_event(FUNC_EDGE, 1'b1, LEVEL_FALL, 64'h1_0000_2AFC);    // high equals period
      push_event(FUNC_READ, 1'b0, 1'b0, 64'h1_0000_2AFC);
      push_event(FUNC_EDGE, 1'b1, LEVEL_RISE, 64'd500);            // time runs backward
      push_event(FUNC_READ, 1'b1, 1'b0, 64'd0);
      push_event(FUNC_EDGE, 1'b1, LEVEL_RISE, 64'hFFFF_FFFF_FFFF_FFFF);
      push_event(FUNC_EDGE, 1'b1, LEVEL_FALL, 64'd0);
      push_event(FUNC_READ, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      push_event(FUNC_EDGE, 1'b0, LEVEL_FALL, 64'd0);
      push_event(FUNC_READ, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      add_random_events(280);
      wait_until_idle();

      // Slowest tick rate.
      write_tick_rate(32'd1);
      add_random_events(150);
      wait_until_idle();

      // Fastest tick rate.
      write_tick_rate(32'hFFFF_FFFF);
      add_random_events(150);
      wait_until_idle();

      write_tick_rate(32'd1000);
      add_random_events(150);
      wait_until_idle();

      write_tick_rate(($urandom == 0) ? 32'd1 : $urandom);
      add_random_events(300);
      wait_until_idle();

      write_tick_rate(TPS_RESET);
      add_random_events(300);
      wait_until_idle();

      repeat (READ_LATENCY) @(posedge clock);
      if (!failed && expected_readings.size() == 0) begin
         $display("tb_edge_timestamp_frequency_duty_meter_unit OK");
      end else begin
         $display("tb_edge_timestamp_frequency_duty_meter_unit NOT OK");
      end
      $finish;
   end

endmodule
